>>> rtl/core/kat_pkg.sv
// ----------------------------------------------------------------------------
// Key allowlist table package
// Shared request, response, command and status types, and the request codes.
// ----------------------------------------------------------------------------
package kat_pkg;

  localparam logic [1:0] REQ_CONTAINS = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_REMOVE   = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  localparam int KEY_BITS = 256;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_w0;
    logic [63:0] key_w1;
    logic [63:0] key_w2;
    logic [63:0] key_w3;
    logic [3:0]  position;
  } kat_req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [4:0]  live_count;
    logic [63:0] entry_w0;
    logic [63:0] entry_w1;
    logic [63:0] entry_w2;
    logic [63:0] entry_w3;
  } kat_rsp_t;

  typedef struct packed {
    logic req_load;
    logic scan_rd;
    logic rd_en;
    logic wr_en;
    logic wr_from_rd;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
    logic out_ok;
    logic out_entry;
  } kat_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       cmp_vld;
    logic [1:0] op;
    logic [3:0] pos;
    logic       pos_ok;
    logic       out_busy;
  } kat_sts_t;

endpackage

>>> rtl/core/kat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module kat_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/kat_dpath.sv
// ----------------------------------------------------------------------------
// Key allowlist table datapath
// Request register, entry store, key compare, live count and result register.
// ----------------------------------------------------------------------------
module kat_dpath #(
  parameter int TABLE_CAP = 16,
  localparam int IDX_W = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1,
  localparam int CNT_W = $clog2(TABLE_CAP + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kat_pkg::kat_req_t in_data,
  input  kat_pkg::kat_cmd_t cmd,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [IDX_W-1:0]  res_slot,
  output kat_pkg::kat_sts_t sts,
  output logic [IDX_W-1:0]  hit_idx,
  output logic [CNT_W-1:0]  count,
  output logic              out_valid,
  input  logic              out_stall,
  output kat_pkg::kat_rsp_t out_data
);
  import kat_pkg::*;

  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  kat_req_t             req_r;
  logic [KEY_BITS-1:0]  key;
  logic [KEY_BITS-1:0]  rd_data;
  logic [KEY_BITS-1:0]  wr_data;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  kat_rsp_t             out_data_r;
  kat_rsp_t             out_data_nxt;

  assign key     = {req_r.key_w0, req_r.key_w1, req_r.key_w2, req_r.key_w3};
  assign wr_data = cmd.wr_from_rd ? rd_data : key;

  kat_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_CAP)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_data;
    end
    if (cmd.scan_rd) begin
      cmp_idx_r <= rd_addr;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan_rd;
      count_r   <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.ok         = cmd.out_ok;
    out_data_nxt.slot       = cmd.out_ok ? 4'(res_slot) : 4'd0;
    out_data_nxt.live_count = 5'(count_r);
    if (cmd.out_entry) begin
      out_data_nxt.entry_w0 = rd_data[255:192];
      out_data_nxt.entry_w1 = rd_data[191:128];
      out_data_nxt.entry_w2 = rd_data[127:64];
      out_data_nxt.entry_w3 = rd_data[63:0];
    end
  end

  always_comb begin
    sts          = '0;
    sts.hit      = cmp_vld_r && (rd_data == key);
    sts.cmp_vld  = cmp_vld_r;
    sts.op       = req_r.req_type;
    sts.pos      = req_r.position;
    sts.pos_ok   = CMP_W'(req_r.position) < CMP_W'(count_r);
    sts.out_busy = out_valid_r && out_stall;
  end

  assign hit_idx   = cmp_idx_r;
  assign count     = count_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_CAP))
    else $error("Live count exceeds the table capacity.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r == $past(count_r) - 1'b1))
    else $error("Live count moved by more than one entry.");

endmodule

>>> rtl/core/kat_ctrl.sv
// ----------------------------------------------------------------------------
// Key allowlist table controller
// Sequences the entry scan, the add, the swap remove and the read per request.
// ----------------------------------------------------------------------------
module kat_ctrl #(
  parameter int TABLE_CAP = 16,
  localparam int IDX_W = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1,
  localparam int CNT_W = $clog2(TABLE_CAP + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kat_pkg::kat_sts_t sts,
  input  logic [IDX_W-1:0]  hit_idx,
  input  logic [CNT_W-1:0]  count,
  output kat_pkg::kat_cmd_t cmd,
  output logic [IDX_W-1:0]  rd_addr,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [IDX_W-1:0]  res_slot
);
  import kat_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_RMWR = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] slot_nxt;
  logic             ok_r;
  logic             ok_nxt;
  logic             entry_r;
  logic             entry_nxt;
  logic [CNT_W-1:0] last_cnt;

  assign last_cnt = count - 1'b1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    ok_nxt    = ok_r;
    entry_nxt = entry_r;
    cmd       = '0;
    rd_addr   = idx_r[IDX_W-1:0];
    wr_addr   = slot_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          idx_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.op == REQ_READ) begin
          state_nxt = ST_RD;
        end else if (sts.hit) begin
          slot_nxt  = hit_idx;
          ok_nxt    = 1'b1;
          entry_nxt = 1'b0;
          state_nxt = ST_FIN;
          if (sts.op == REQ_REMOVE) begin
            if (CNT_W'(hit_idx) == last_cnt) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en = 1'b1;
              rd_addr   = last_cnt[IDX_W-1:0];
              state_nxt = ST_RMWR;
            end
          end
        end else if ((idx_r == count) && !sts.cmp_vld) begin
          entry_nxt = 1'b0;
          state_nxt = ST_FIN;
          if ((sts.op == REQ_ADD) && (count < CNT_W'(TABLE_CAP))) begin
            cmd.wr_en   = 1'b1;
            wr_addr     = count[IDX_W-1:0];
            cmd.cnt_inc = 1'b1;
            ok_nxt      = 1'b1;
            slot_nxt    = count[IDX_W-1:0];
          end else begin
            ok_nxt   = 1'b0;
            slot_nxt = '0;
          end
        end else if (idx_r < count) begin
          cmd.scan_rd = 1'b1;
          cmd.rd_en   = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end
      end
      ST_RD: begin
        state_nxt = ST_FIN;
        if (sts.pos_ok) begin
          cmd.rd_en = 1'b1;
          rd_addr   = IDX_W'(sts.pos);
          slot_nxt  = IDX_W'(sts.pos);
          ok_nxt    = 1'b1;
          entry_nxt = 1'b1;
        end else begin
          slot_nxt  = '0;
          ok_nxt    = 1'b0;
          entry_nxt = 1'b0;
        end
      end
      ST_RMWR: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_from_rd = 1'b1;
        cmd.cnt_dec    = 1'b1;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_ok    = ok_r;
          cmd.out_entry = entry_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_slot = slot_r;

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    ok_r    <= ok_nxt;
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("A new transfer was taken while a request was in progress.");

  a_wr_no_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !sts.cmp_vld)
    else $error("Entry write issued while a key compare was outstanding.");

endmodule

>>> rtl/core/key_allowlist_table.sv
// Operation: a search reads the live entries in order until a hit or the end of
// the live entries; a swap remove of any but the last entry also moves the last
// entry into the freed slot; a read request reads the entry at its position.
// Throughput: one request at a time; the next can be taken once the result is presented.
// Reset: synchronous active-low reset empties the table; entry contents are
// not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// Key allowlist table
// Bounded set of 256-bit keys with contains, add, swap remove and read-at.
// ----------------------------------------------------------------------------
module key_allowlist_table #(
  parameter int TABLE_CAP = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kat_pkg::kat_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kat_pkg::kat_rsp_t out_data
);
  import kat_pkg::*;

  localparam int IDX_W = (TABLE_CAP > 1) ? $clog2(TABLE_CAP) : 1;
  localparam int CNT_W = $clog2(TABLE_CAP + 1);

  kat_cmd_t         cmd;
  kat_sts_t         sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] res_slot;
  logic [IDX_W-1:0] hit_idx;
  logic [CNT_W-1:0] count;

  kat_ctrl #(
    .TABLE_CAP(TABLE_CAP)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .hit_idx (hit_idx),
    .count   (count),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .res_slot(res_slot)
  );

  kat_dpath #(
    .TABLE_CAP(TABLE_CAP)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .res_slot (res_slot),
    .sts      (sts),
    .hit_idx  (hit_idx),
    .count    (count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> dv/key_allowlist_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key allowlist table testbench
// Drives contains, add, remove and read requests through the request channel,
// predicts each response from a shadow copy of the table, and compares every
// response field with the prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module key_allowlist_table_test;
  import kat_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int POOL_KEYS   = 24;
  localparam int RANDOM_REQS = 1400;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kat_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kat_rsp_t out_data;

  kat_req_t       req_backlog[$];
  kat_rsp_t       predicted_rsps[$];
  logic [255:0]   shadow_keys[TABLE_SLOTS];
  int             shadow_count = 0;
  logic [255:0]   key_pool[POOL_KEYS];
  int             sent_count   = 0;
  int             recv_count   = 0;
  int             send_wait    = 0;
  int             recv_wait    = 0;
  int             pressure_cycle = 0;
  logic           hold_out     = 1'b0;
  bit             mismatch_seen = 1'b0;

  key_allowlist_table #(.TABLE_CAP(TABLE_SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Every fourth run of fifty transfers goes without any idle cycles.
  function automatic int draw_wait(int done);
    if (((done / 50) % 4) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic int find_shadow(logic [255:0] key);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic kat_rsp_t predict_table_op(kat_req_t req);
    kat_rsp_t     rsp;
    logic [255:0] key;
    int           hit;
    int           n;
    rsp = '0;
    key = {req.key_w0, req.key_w1, req.key_w2, req.key_w3};
    n = shadow_count;
    hit = find_shadow(key);
    case (req.req_type)
      REQ_CONTAINS: begin
        if (hit >= 0) begin
          rsp.ok = 1'b1;
          rsp.slot = 4'(hit);
        end
      end
      REQ_ADD: begin
        if (hit >= 0) begin
          rsp.ok = 1'b1;
          rsp.slot = 4'(hit);
        end else if (n < TABLE_SLOTS) begin
          shadow_keys[n] = key;
          shadow_count = n + 1;
          rsp.ok = 1'b1;
          rsp.slot = 4'(n);
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          // The last live entry moves into the freed slot.
          if (hit != n - 1) shadow_keys[hit] = shadow_keys[n - 1];
          shadow_count = n - 1;
          rsp.ok = 1'b1;
          rsp.slot = 4'(hit);
        end
      end
      default: begin
        if (int'(req.position) < n) begin
          rsp.ok = 1'b1;
          rsp.slot = req.position;
          {rsp.entry_w0, rsp.entry_w1, rsp.entry_w2, rsp.entry_w3} =
            shadow_keys[req.position];
        end
      end
    endcase
    rsp.live_count = 5'(shadow_count);
    return rsp;
  endfunction

  task automatic queue_req(logic [1:0] op, logic [255:0] key, logic [3:0] pos);
    kat_req_t req;
    req.req_type = op;
    {req.key_w0, req.key_w1, req.key_w2, req.key_w3} = key;
    req.position = pos;
    req_backlog.push_back(req);
  endtask

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, field, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        predicted_rsps.push_back(predict_table_op(in_data));
        sent_count = sent_count + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
        end else if (req_backlog.size() > 0) begin
          in_data <= req_backlog.pop_front();
          offer = 1'b1;
          send_wait <= draw_wait(sent_count);
        end
      end
      in_valid <= offer;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    kat_rsp_t want;
    int       w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_valid && !out_stall) begin
        if (predicted_rsps.size() == 0) begin
          $display("%0t: response expected none, actual %h", $time, out_data);
          mismatch_seen = 1'b1;
        end else begin
          want = predicted_rsps.pop_front();
          check_field("ok", 64'(want.ok), 64'(out_data.ok));
          check_field("slot", 64'(want.slot), 64'(out_data.slot));
          check_field("live_count", 64'(want.live_count), 64'(out_data.live_count));
          check_field("entry_w0", want.entry_w0, out_data.entry_w0);
          check_field("entry_w1", want.entry_w1, out_data.entry_w1);
          check_field("entry_w2", want.entry_w2, out_data.entry_w2);
          check_field("entry_w3", want.entry_w3, out_data.entry_w3);
        end
        recv_count = recv_count + 1;
        w = draw_wait(recv_count);
      end
      out_stall <= hold_out || (w > 0);
      recv_wait <= (w > 0) ? w - 1 : 0;
    end
  end

  // Long receiver hold-offs so that the table backs up into the request side.
  always @(posedge clk) begin
    pressure_cycle <= pressure_cycle + 1;
    hold_out <= (pressure_cycle >= 2000 && pressure_cycle < 2400) ||
                (pressure_cycle >= 15000 && pressure_cycle < 15400);
  end

  initial begin
    logic [255:0] key;
    logic [1:0]   op;
    int           pick;
    int           flip;
    bit           grow;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = rand_key();

    queue_req(REQ_CONTAINS, key_pool[2], 4'd0);
    queue_req(REQ_REMOVE, key_pool[2], 4'd0);
    queue_req(REQ_READ, rand_key(), 4'd0);
    queue_req(REQ_ADD, key_pool[0], 4'd15);
    queue_req(REQ_ADD, key_pool[1], 4'd0);
    queue_req(REQ_ADD, key_pool[0], 4'd0);
    queue_req(REQ_CONTAINS, key_pool[1], 4'd0);
    key = key_pool[1];
    key[0] = 1'b0;
    queue_req(REQ_CONTAINS, key, 4'd0);
    queue_req(REQ_READ, '0, 4'd1);
    queue_req(REQ_READ, '1, 4'd15);
    queue_req(REQ_REMOVE, key_pool[1], 4'd0);
    for (int i = 2; i < TABLE_SLOTS + 1; i++) queue_req(REQ_ADD, key_pool[i], 4'd0);
    queue_req(REQ_ADD, key_pool[TABLE_SLOTS + 1], 4'd0);
    queue_req(REQ_READ, '0, 4'd15);
    queue_req(REQ_REMOVE, key_pool[0], 4'd0);
    queue_req(REQ_READ, '0, 4'd0);

    // Alternate add-heavy and remove-heavy stretches so the table swings
    // between empty and full.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      grow = ((i / 60) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (grow)
        op = (pick < 55) ? REQ_ADD : (pick < 65) ? REQ_REMOVE :
             (pick < 85) ? REQ_CONTAINS : REQ_READ;
      else
        op = (pick < 15) ? REQ_ADD : (pick < 60) ? REQ_REMOVE :
             (pick < 80) ? REQ_CONTAINS : REQ_READ;
      key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        key = rand_key();
      end else if (pick == 1) begin
        flip = $urandom_range(0, 255);
        key[flip] = ~key[flip];
      end
      queue_req(op, key, 4'($urandom_range(0, 15)));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() > 0 || in_valid) @(posedge clk);
    while (predicted_rsps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!mismatch_seen)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
